@@ rtl/core/pump_drive_run_sequencer_macros.svh @@
// Assertion macros for the pump drive run sequencer.
`ifndef PUMP_DRIVE_RUN_SEQUENCER_MACROS_SVH
`define PUMP_DRIVE_RUN_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pds check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pds check failed");

`endif

@@ rtl/core/pds_pkg.sv @@
// Shared types, constants and codes of the pump drive run sequencer.
`default_nettype none
package pds_pkg;

    // Ramp timing and full speed
    localparam int unsigned RAMP_MS       = 2000;
    localparam int unsigned FULL_SPEED_HZ = 490;

    // Field widths
    localparam int unsigned HZ_W   = 9;
    localparam int unsigned AMPS_W = 8;
    localparam int unsigned CW_W   = 16;
    localparam int unsigned PR_W   = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned FLT_W  = 16;
    localparam int unsigned STAT_W = 16;
    localparam int unsigned PVAL_W = 32;

    // Ramp arithmetic: x * FULL_SPEED_HZ / RAMP_MS through a reciprocal
    localparam int unsigned X_W          = $clog2(RAMP_MS + 1);
    localparam int unsigned P_W          = $clog2(RAMP_MS * FULL_SPEED_HZ + 1);
    localparam int unsigned RECIP_SHIFT  = 31;
    localparam longint unsigned RECIP    = (64'd1 << RECIP_SHIFT) / RAMP_MS;
    localparam int unsigned R_W          = $clog2(RECIP + 1);
    localparam int unsigned Q_W          = $clog2(FULL_SPEED_HZ + 1);

    // Speed and current levels
    localparam int unsigned DECEL_FLOOR_HZ    = 3;
    localparam logic [AMPS_W-1:0] AMPS_RUN    = AMPS_W'(11);  // 1.1 A
    localparam logic [AMPS_W-1:0] AMPS_ACCEL  = AMPS_W'(152); // 15.2 A
    localparam logic [HZ_W-1:0] HZ_FULL       = HZ_W'(FULL_SPEED_HZ);

    // Control word bits
    localparam int unsigned CW_RUN_BIT    = 0;
    localparam int unsigned CW_RESET_BIT  = 7;
    localparam int unsigned CW_REMOTE_BIT = 10;

    // Parameter request
    localparam int unsigned PR_VALID_BIT = 12;
    localparam int unsigned PNUM_W       = 12;
    localparam logic [PNUM_W-1:0] PNUM_FIRMWARE  = PNUM_W'(2);
    localparam logic [PNUM_W-1:0] PNUM_SPEED     = PNUM_W'(3);
    localparam logic [PNUM_W-1:0] PNUM_DCLINK    = PNUM_W'(4);
    localparam logic [PNUM_W-1:0] PNUM_AMPS      = PNUM_W'(5);
    localparam logic [PNUM_W-1:0] PNUM_PUMP_TEMP = PNUM_W'(7);
    localparam logic [PNUM_W-1:0] PNUM_CONV_TEMP = PNUM_W'(11);
    localparam logic [PNUM_W-1:0] PNUM_FAULT     = PNUM_W'(171);
    localparam logic [PNUM_W-1:0] PNUM_TEMP_WARN = PNUM_W'(227);
    localparam logic [PNUM_W-1:0] PNUM_LOAD_WARN = PNUM_W'(230);

    // Status word bits
    localparam int unsigned SB_TEMP_WARN  = 2;
    localparam int unsigned SB_FAULT      = 3;
    localparam int unsigned SB_ACCEL      = 4;
    localparam int unsigned SB_DECEL      = 5;
    localparam int unsigned SB_ON         = 10;
    localparam int unsigned SB_COAST      = 11;
    localparam int unsigned SB_LOAD_WARN  = 13;
    localparam int unsigned SB_PURGE_WARN = 14;
    localparam int unsigned SB_REMOTE     = 15;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_TEMP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_TEMP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DC_LINK    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WARN  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_WARN  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_PURGE_WARN = CFG_IDX_W'(6);

    // Request queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PSEL_NONE,
        PSEL_FIRMWARE,
        PSEL_SPEED,
        PSEL_DCLINK,
        PSEL_AMPS,
        PSEL_PUMP_TEMP,
        PSEL_CONV_TEMP,
        PSEL_FAULT,
        PSEL_TEMP_WARN,
        PSEL_LOAD_WARN
    } psel_t;

    // Classified request as it leaves the front end
    typedef struct packed {
        logic              remote;
        logic              run_bit;
        logic              fault_reset;
        logic [TIME_W-1:0] now_ms;
        logic [FLT_W-1:0]  fault_event;
        psel_t             psel;
    } item_t;

    // Queue status toward the front and back ends
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_LVL_W-1:0] level;
    } qstat_t;

endpackage
`default_nettype wire

@@ rtl/core/pump_drive_run_sequencer.sv @@
// Top level of the pump drive run sequencer.
// One request a cycle is taken while the queue is not full; each gives one
// reply, registered through s1, s2, s3 and the reply register, after it
// leaves the request queue. The back end sustains one request per clock
// unless rsp_stall holds it, as its run state update reads the state the
// previous request left. A four-entry queue sits between the decoding
// front end and the back end and takes new requests while the last reply
// waits: rsp_stall freezes the back end, and req_stall rises only once the
// queue is full. Speed on a ramp is elapsed * 490 / 2000 Hz, computed with a
// constant multiply, a reciprocal multiply and a one-step correction over
// three pipeline stages; speed and current are held in the back end and read
// out with each reply. Settings are written through the cfg port (always
// ready) and must only be changed while no request is in flight.
`default_nettype none
`include "pump_drive_run_sequencer_macros.svh"
module pump_drive_run_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [pds_pkg::CW_W-1:0]       control_word,
    input  wire logic [pds_pkg::PR_W-1:0]       param_request,
    input  wire logic [pds_pkg::TIME_W-1:0]     now_ms,
    input  wire logic [pds_pkg::FLT_W-1:0]      fault_event,
    // reply channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic [pds_pkg::STAT_W-1:0]          status_word,
    output logic [pds_pkg::HZ_W-1:0]            speed_hz,
    output logic [7:0]                          converter_temp_out,
    output logic [pds_pkg::AMPS_W-1:0]          motor_amps_x10,
    output logic [7:0]                          pump_temp_out,
    output logic [15:0]                         dc_link_out,
    output logic [pds_pkg::PVAL_W-1:0]          param_value,
    // settings write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pds_pkg::*;

    item_t  fe_item;
    item_t  q_head;
    qstat_t q_stat;
    logic   q_push;
    logic   q_pop;

    assign cfg_ready = 1'b1;

    // Decode control word and parameter number
    pds_front u_front (
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .control_word  (control_word),
        .param_request (param_request),
        .now_ms        (now_ms),
        .fault_event   (fault_event),
        .qstat         (q_stat),
        .push          (q_push),
        .item          (fe_item)
    );

    pds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (fe_item),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (q_stat)
    );

    // Run state, speed ramp and reply
    pds_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (q_head),
        .qstat              (q_stat),
        .pop                (q_pop),
        .cfg_valid          (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .status_word        (status_word),
        .speed_hz           (speed_hz),
        .converter_temp_out (converter_temp_out),
        .motor_amps_x10     (motor_amps_x10),
        .pump_temp_out      (pump_temp_out),
        .dc_link_out        (dc_link_out),
        .param_value        (param_value)
    );

    // Back end never pops an empty queue
    `PDS_ASSERT_NOW(a_pop_nonempty, q_pop, q_stat.level != '0)
    // At most one run phase flagged in a reply
    `PDS_ASSERT_NOW(a_phase_onehot, rsp_valid,
        $onehot0({status_word[SB_ON], status_word[SB_ACCEL],
                  status_word[SB_DECEL], status_word[SB_COAST]}))
    // A faulted reply always reports a stopped drive
    `PDS_ASSERT_NOW(a_fault_stops, rsp_valid && status_word[SB_FAULT], speed_hz == '0)

endmodule
`default_nettype wire

@@ rtl/core/pds_front.sv @@
// Front end: takes requests and decodes control and parameter fields.
`default_nettype none
module pds_front (
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [pds_pkg::CW_W-1:0]  control_word,
    input  wire logic [pds_pkg::PR_W-1:0]  param_request,
    input  wire logic [pds_pkg::TIME_W-1:0] now_ms,
    input  wire logic [pds_pkg::FLT_W-1:0] fault_event,
    input  wire pds_pkg::qstat_t           qstat,
    output logic                           push,
    output pds_pkg::item_t                 item
);
    import pds_pkg::*;

    logic [PNUM_W-1:0] pnum;

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;

    assign pnum = param_request[PR_VALID_BIT] ? param_request[PNUM_W-1:0] : '0;

    always_comb
    begin
        item.remote      = control_word[CW_REMOTE_BIT];
        item.run_bit     = control_word[CW_RUN_BIT];
        item.fault_reset = control_word[CW_RESET_BIT];
        item.now_ms      = now_ms;
        item.fault_event = fault_event;
        unique case (pnum)
            PNUM_FIRMWARE:  item.psel = PSEL_FIRMWARE;
            PNUM_SPEED:     item.psel = PSEL_SPEED;
            PNUM_DCLINK:    item.psel = PSEL_DCLINK;
            PNUM_AMPS:      item.psel = PSEL_AMPS;
            PNUM_PUMP_TEMP: item.psel = PSEL_PUMP_TEMP;
            PNUM_CONV_TEMP: item.psel = PSEL_CONV_TEMP;
            PNUM_FAULT:     item.psel = PSEL_FAULT;
            PNUM_TEMP_WARN: item.psel = PSEL_TEMP_WARN;
            PNUM_LOAD_WARN: item.psel = PSEL_LOAD_WARN;
            default:        item.psel = PSEL_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/pds_queue.sv @@
// Short FIFO of decoded requests between front and back ends.
`default_nettype none
module pds_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pds_pkg::item_t push_item,
    input  wire logic           pop,
    output pds_pkg::item_t      head,
    output pds_pkg::qstat_t     qstat
);
    import pds_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_LVL_W-1:0] level_reg;
    logic [Q_LVL_W-1:0] level_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.level = level_reg;
    assign qstat.empty = (level_reg == '0);
    assign qstat.full  = (level_reg == Q_LVL_W'(Q_DEPTH));

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

@@ rtl/core/pds_back.sv @@
// Back end: run state machine, speed ramp pipeline, settings and reply register.
`default_nettype none
module pds_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pds_pkg::item_t                head,
    input  wire pds_pkg::qstat_t               qstat,
    output logic                               pop,
    input  wire logic                          cfg_valid,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [pds_pkg::STAT_W-1:0]         status_word,
    output logic [pds_pkg::HZ_W-1:0]           speed_hz,
    output logic [7:0]                         converter_temp_out,
    output logic [pds_pkg::AMPS_W-1:0]         motor_amps_x10,
    output logic [7:0]                         pump_temp_out,
    output logic [15:0]                        dc_link_out,
    output logic [pds_pkg::PVAL_W-1:0]         param_value
);
    import pds_pkg::*;

    typedef enum logic [2:0] {
        ST_OFF   = 3'd0,
        ST_ACCEL = 3'd1,
        ST_ON    = 3'd2,
        ST_DECEL = 3'd3,
        ST_COAST = 3'd4
    } run_state_t;

    typedef enum logic [2:0] {
        SP_HOLD,
        SP_FULL,
        SP_RAMP,
        SP_DECEL,
        SP_FLOOR,
        SP_ZERO
    } speed_op_t;

    typedef struct packed {
        speed_op_t         op;
        logic [X_W-1:0]    x;
        logic [STAT_W-1:0] status;
        logic [AMPS_W-1:0] amps_before;
        logic [AMPS_W-1:0] amps_after;
        logic [FLT_W-1:0]  fault;
        psel_t             psel;
    } pipe_t;

    localparam int unsigned PR_MUL_W = P_W + R_W;
    localparam logic [P_W-1:0]      FULL_P   = P_W'(FULL_SPEED_HZ);
    localparam logic [P_W-1:0]      RAMP_P   = P_W'(RAMP_MS);
    localparam logic [TIME_W-1:0]   RAMP_T   = TIME_W'(RAMP_MS);
    localparam logic [PR_MUL_W-1:0] RECIP_M  = PR_MUL_W'(RECIP);
    localparam logic [HZ_W-1:0]     HZ_FLOOR = HZ_W'(DECEL_FLOOR_HZ);

    // Settings
    logic [7:0]            conv_temp_reg;
    logic [7:0]            pump_temp_reg;
    logic [15:0]           dc_link_reg;
    logic [16:0]           firmware_reg;
    logic [15:0]           temp_warn_reg;
    logic [15:0]           load_warn_reg;
    logic [15:0]           purge_warn_reg;

    // Drive state
    run_state_t            state_reg;
    run_state_t            state_next;
    logic [TIME_W-1:0]     start_reg;
    logic [TIME_W-1:0]     start_next;
    logic [AMPS_W-1:0]     amps_reg;
    logic [AMPS_W-1:0]     amps_next;
    logic [FLT_W-1:0]      fault_reg;
    logic [FLT_W-1:0]      fault_next;
    logic [HZ_W-1:0]       hz_reg;
    logic [HZ_W-1:0]       hz_next;

    // Pipeline
    logic                  adv;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  out_v_reg;
    pipe_t                 s1_reg;
    pipe_t                 s1_next;
    pipe_t                 s2_reg;
    pipe_t                 s3_reg;
    logic [P_W-1:0]        p2_reg;
    logic [P_W-1:0]        p3_reg;
    logic [Q_W-1:0]        q0_reg;
    logic [PR_MUL_W-1:0]   recip_prod;
    logic [P_W-1:0]        rem;
    logic [Q_W-1:0]        quot;
    logic [STAT_W-1:0]     status_reg;
    logic [AMPS_W-1:0]     amps_out_reg;
    logic [PVAL_W-1:0]     pval_reg;
    logic [PVAL_W-1:0]     pval_next;

    // Stage 1 decode
    logic [TIME_W-1:0]     elapsed;
    logic                  ramp_done;
    logic                  running;

    assign adv = !out_v_reg || !rsp_stall;
    assign pop = adv && !qstat.empty;

    // Run state step for the request at the queue head
    always_comb
    begin
        elapsed    = head.now_ms - start_reg;
        ramp_done  = (elapsed >= RAMP_T);
        fault_next = (head.fault_event != '0) ? head.fault_event : fault_reg;
        if (head.remote && head.fault_reset && state_reg == ST_OFF)
            fault_next = '0;
        running    = head.remote ? head.run_bit
                                 : (state_reg == ST_ON || state_reg == ST_ACCEL);

        state_next = state_reg;
        start_next = start_reg;
        amps_next  = amps_reg;
        s1_next    = '0;
        s1_next.op = SP_HOLD;

        if (running && state_reg != ST_ON)
        begin
            if (state_reg == ST_OFF)
            begin
                state_next = ST_ACCEL;
                amps_next  = AMPS_ACCEL;
                start_next = head.now_ms;
            end
            else if (ramp_done)
            begin
                s1_next.op = SP_FULL;
                amps_next  = AMPS_RUN;
                state_next = ST_ON;
                start_next = head.now_ms;
            end
            else
            begin
                s1_next.op = SP_RAMP;
                s1_next.x  = elapsed[X_W-1:0];
            end
        end
        else if (!running && state_reg != ST_OFF)
        begin
            if (state_reg == ST_ON)
            begin
                state_next = ST_DECEL;
                start_next = head.now_ms;
            end
            else if (state_reg == ST_DECEL)
            begin
                if (ramp_done)
                begin
                    s1_next.op = SP_FLOOR;
                    state_next = ST_COAST;
                    start_next = head.now_ms;
                end
                else
                begin
                    s1_next.op = SP_DECEL;
                    s1_next.x  = X_W'(RAMP_T - elapsed);
                end
            end
            else if (state_reg == ST_COAST && ramp_done)
            begin
                s1_next.op = SP_ZERO;
                state_next = ST_OFF;
                start_next = head.now_ms;
            end
        end

        unique case (state_next)
            ST_ON:    s1_next.status[SB_ON]    = 1'b1;
            ST_ACCEL: s1_next.status[SB_ACCEL] = 1'b1;
            ST_DECEL: s1_next.status[SB_DECEL] = 1'b1;
            ST_COAST: s1_next.status[SB_COAST] = 1'b1;
            default:  ;
        endcase
        s1_next.status[SB_REMOTE] = head.remote;

        if (fault_next != '0)
        begin
            s1_next.status[SB_FAULT] = 1'b1;
            s1_next.op = SP_ZERO;
            state_next = ST_OFF;
        end
        s1_next.status[SB_TEMP_WARN]  = (temp_warn_reg != '0);
        s1_next.status[SB_LOAD_WARN]  = (load_warn_reg != '0);
        s1_next.status[SB_PURGE_WARN] = (purge_warn_reg != '0);

        s1_next.amps_before = amps_reg;
        s1_next.amps_after  = amps_next;
        s1_next.fault       = fault_next;
        s1_next.psel        = head.psel;
    end

    // Reciprocal divide: q0 may be one short, fixed by the remainder
    assign recip_prod = PR_MUL_W'(p2_reg) * RECIP_M;
    assign rem        = p3_reg - P_W'(q0_reg) * RAMP_P;
    assign quot       = (rem >= RAMP_P) ? Q_W'(q0_reg + 1'b1) : q0_reg;

    always_comb
    begin
        unique case (s3_reg.op)
            SP_HOLD:  hz_next = hz_reg;
            SP_FULL:  hz_next = HZ_FULL;
            SP_RAMP:  hz_next = HZ_W'(quot);
            SP_DECEL: hz_next = (32'(quot) < 32'(DECEL_FLOOR_HZ)) ? HZ_FLOOR : HZ_W'(quot);
            SP_FLOOR: hz_next = HZ_FLOOR;
            SP_ZERO:  hz_next = '0;
            default:  hz_next = hz_reg;
        endcase
    end

    always_comb
    begin
        unique case (s3_reg.psel)
            PSEL_NONE:      pval_next = '0;
            PSEL_FIRMWARE:  pval_next = PVAL_W'(firmware_reg);
            PSEL_SPEED:     pval_next = PVAL_W'(hz_next);
            PSEL_DCLINK:    pval_next = PVAL_W'(dc_link_reg);
            PSEL_AMPS:      pval_next = PVAL_W'(s3_reg.amps_after);
            PSEL_PUMP_TEMP: pval_next = PVAL_W'(pump_temp_reg);
            PSEL_CONV_TEMP: pval_next = PVAL_W'(conv_temp_reg);
            PSEL_FAULT:     pval_next = PVAL_W'(s3_reg.fault);
            PSEL_TEMP_WARN: pval_next = PVAL_W'(temp_warn_reg);
            PSEL_LOAD_WARN: pval_next = PVAL_W'(load_warn_reg);
            default:        pval_next = '0;
        endcase
    end

    // Control state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ON;
            start_reg <= '0;
            amps_reg  <= AMPS_RUN;
            fault_reg <= '0;
            hz_reg    <= HZ_FULL;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                start_reg <= start_next;
                amps_reg  <= amps_next;
                fault_reg <= fault_next;
            end
            if (adv)
            begin
                v1_reg    <= pop;
                v2_reg    <= v1_reg;
                v3_reg    <= v2_reg;
                out_v_reg <= v3_reg;
                if (v3_reg)
                    hz_reg <= hz_next;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s1_reg;
            p2_reg       <= P_W'(s1_reg.x) * FULL_P;
            s3_reg       <= s2_reg;
            p3_reg       <= p2_reg;
            q0_reg       <= Q_W'(recip_prod >> RECIP_SHIFT);
            status_reg   <= s3_reg.status;
            amps_out_reg <= s3_reg.amps_before;
            pval_reg     <= pval_next;
        end
    end

    // Settings writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_temp_reg  <= 8'd50;
            pump_temp_reg  <= 8'd65;
            dc_link_reg    <= 16'd602;
            firmware_reg   <= '0;
            temp_warn_reg  <= '0;
            load_warn_reg  <= '0;
            purge_warn_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CONV_TEMP:  conv_temp_reg  <= cfg_data[7:0];
                CFG_PUMP_TEMP:  pump_temp_reg  <= cfg_data[7:0];
                CFG_DC_LINK:    dc_link_reg    <= cfg_data[15:0];
                CFG_FIRMWARE:   firmware_reg   <= cfg_data[16:0];
                CFG_TEMP_WARN:  temp_warn_reg  <= cfg_data[15:0];
                CFG_LOAD_WARN:  load_warn_reg  <= cfg_data[15:0];
                CFG_PURGE_WARN: purge_warn_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    assign rsp_valid          = out_v_reg;
    assign status_word        = status_reg;
    assign speed_hz           = hz_reg;
    assign motor_amps_x10     = amps_out_reg;
    assign param_value        = pval_reg;
    assign converter_temp_out = conv_temp_reg;
    assign pump_temp_out      = pump_temp_reg;
    assign dc_link_out        = dc_link_reg;

endmodule
`default_nettype wire
